// ----- rtl/core/pbd_pkg.sv -----
package pbd_pkg;

   // default build limits
   localparam int MAX_PLANES_DEF  = 8;
   localparam int MAX_WIDTH_DEF   = 16384;
   localparam int MAX_HEIGHT_DEF  = 4096;
   localparam int QUEUE_DEPTH_DEF = 2;

   // decode phases
   localparam logic [1:0] PH_CONTROL = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_REPEAT  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_CONSUMED = 3'd0;
   localparam logic [2:0] ST_WRITTEN  = 3'd1;
   localparam logic [2:0] ST_TRUNC    = 3'd2;
   localparam logic [2:0] ST_OVERRUN  = 3'd3;
   localparam logic [2:0] ST_BADMODE  = 3'd4;
   localparam logic [2:0] ST_IGNORED  = 3'd5;

   // compression modes
   localparam logic [7:0] MODE_RAW     = 8'd0;
   localparam logic [7:0] MODE_BYTERUN = 8'd1;

   // control byte that does nothing
   localparam logic [7:0] NOOP_CODE = 8'h80;

   // register indexes
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_PLANES = 2'd3;

   // register reset values
   localparam logic [7:0]  MODE_RST   = 8'd1;
   localparam logic [14:0] WIDTH_RST  = 15'd320;
   localparam logic [12:0] HEIGHT_RST = 13'd256;
   localparam logic [3:0]  PLANES_RST = 4'd5;

   typedef struct packed {
      logic [7:0]  mode;
      logic [14:0] width;
      logic [12:0] height;
      logic [3:0]  planes;
   } cfg_type;

   // classified request
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       noop;
      logic       lit_ctrl;
      logic [7:0] ctrl_n;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  byte_value;
      logic [7:0]  repeat_count;
      logic [2:0]  plane_index;
      logic [11:0] row_index;
      logic [10:0] column_start;
      logic        image_done;
   } rsp_type;

endpackage

// ----- rtl/core/pbd_front.sv -----
module pbd_front
   import pbd_pkg::*;
(
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] data_byte,
   input  logic       first_byte,
   input  logic       last_byte,
   input  logic       queue_full,
   output logic       push,
   output item_type   item
);

   logic [8:0] lit_sum;
   logic [8:0] rep_sum;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // literal run: c+1 bytes; repeat run: 257-c copies
   assign lit_sum = {1'b0, data_byte} + 9'd1;
   assign rep_sum = 9'd257 - {1'b0, data_byte};

   always_comb begin
      item.data     = data_byte;
      item.first    = first_byte;
      item.last     = last_byte;
      item.noop     = (data_byte == NOOP_CODE);
      item.lit_ctrl = !data_byte[7];
      item.ctrl_n   = data_byte[7] ? rep_sum[7:0] : lit_sum[7:0];
   end

endmodule

// ----- rtl/core/pbd_queue.sv -----
module pbd_queue
   import pbd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head,
   output logic     full,
   output logic     not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/pbd_back.sv -----
module pbd_back
   import pbd_pkg::*;
#(
   parameter int MAX_PLANES = MAX_PLANES_DEF,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   input  item_type item,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   localparam int MAX_RB = ((MAX_WIDTH + 15) / 16) * 2;
   localparam int COL_W  = $clog2(MAX_RB);
   localparam int RB_W   = $clog2(MAX_RB + 1);
   localparam int SUM_W  = COL_W + 9;
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       lit_left_ff, lit_left_in;
   logic [7:0]       rep_ff, rep_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [2:0]       plane_ff, plane_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             fin_ff, fin_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   // clamped geometry
   logic [15:0]      w16, wcl;
   logic [16:0]      rb17;
   logic [RB_W-1:0]  rb;
   logic [3:0]       planes;
   logic [15:0]      h16, hcl;

   // state seen by this byte, after an optional restart
   logic [1:0]       cur_phase;
   logic [7:0]       cur_lit, cur_rep;
   logic [COL_W-1:0] cur_col;
   logic [2:0]       cur_plane;
   logic [ROW_W-1:0] cur_row;
   logic             cur_fin, cur_err;

   logic             do_write;
   logic [7:0]       wr_n;
   logic [SUM_W-1:0] col_sum, rb_ext, left;
   logic [3:0]       plane_inc;
   logic [15:0]      row_inc;
   logic [31:0]      col32, row32;

   assign pop       = in_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      w16 = {1'b0, cfg.width};
      if (w16 == 16'd0) begin
         wcl = 16'd1;
      end else if (w16 > 16'(MAX_WIDTH)) begin
         wcl = 16'(MAX_WIDTH);
      end else begin
         wcl = w16;
      end
      rb17 = (({1'b0, wcl} + 17'd15) >> 4) << 1;
      rb   = rb17[RB_W-1:0];

      if (cfg.planes == 4'd0) begin
         planes = 4'd1;
      end else if (cfg.planes > 4'(MAX_PLANES)) begin
         planes = 4'(MAX_PLANES);
      end else begin
         planes = cfg.planes;
      end

      h16 = {3'b000, cfg.height};
      if (h16 == 16'd0) begin
         hcl = 16'd1;
      end else if (h16 > 16'(MAX_HEIGHT)) begin
         hcl = 16'(MAX_HEIGHT);
      end else begin
         hcl = h16;
      end
   end

   always_comb begin
      if (item.first) begin
         cur_phase = PH_CONTROL;
         cur_lit   = '0;
         cur_rep   = '0;
         cur_col   = '0;
         cur_plane = '0;
         cur_row   = '0;
         cur_fin   = 1'b0;
         cur_err   = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_lit   = lit_left_ff;
         cur_rep   = rep_ff;
         cur_col   = col_ff;
         cur_plane = plane_ff;
         cur_row   = row_ff;
         cur_fin   = fin_ff;
         cur_err   = err_ff;
      end

      phase_in    = cur_phase;
      lit_left_in = cur_lit;
      rep_in      = cur_rep;
      col_in      = cur_col;
      plane_in    = cur_plane;
      row_in      = cur_row;
      fin_in      = cur_fin;
      err_in      = cur_err;
      rsp_in      = '0;
      rsp_in.status = ST_CONSUMED;

      rb_ext = SUM_W'(rb);
      left   = (rb_ext > SUM_W'(cur_col)) ? rb_ext - SUM_W'(cur_col) : '0;

      do_write = 1'b0;
      wr_n     = (cur_phase == PH_REPEAT && cfg.mode == MODE_BYTERUN) ? cur_rep : 8'd1;

      if (cur_fin || cur_err) begin
         rsp_in.status = ST_IGNORED;
      end else if (cfg.mode == MODE_RAW) begin
         do_write = 1'b1;
      end else if (cfg.mode == MODE_BYTERUN) begin
         case (cur_phase)
            PH_LITERAL: begin
               do_write    = 1'b1;
               lit_left_in = (cur_lit != 8'd0) ? cur_lit - 8'd1 : cur_lit;
               if (lit_left_in == 8'd0) begin
                  phase_in = PH_CONTROL;
               end
            end
            PH_REPEAT: begin
               do_write = 1'b1;
               rep_in   = '0;
               phase_in = PH_CONTROL;
            end
            default: begin
               if (item.last) begin
                  rsp_in.status = ST_TRUNC;
                  err_in        = 1'b1;
               end else if (item.noop) begin
                  rsp_in.status = ST_CONSUMED;
               end else if (SUM_W'(item.ctrl_n) > left) begin
                  rsp_in.status = ST_OVERRUN;
                  err_in        = 1'b1;
               end else if (item.lit_ctrl) begin
                  phase_in    = PH_LITERAL;
                  lit_left_in = item.ctrl_n;
               end else begin
                  phase_in = PH_REPEAT;
                  rep_in   = item.ctrl_n;
               end
            end
         endcase
      end else begin
         rsp_in.status = ST_BADMODE;
         err_in        = 1'b1;
      end

      // advance the position past a written run
      col_sum   = SUM_W'(cur_col) + SUM_W'(wr_n);
      plane_inc = {1'b0, cur_plane} + 4'd1;
      row_inc   = 16'(cur_row) + 16'd1;
      col32     = 32'(cur_col);
      row32     = 32'(cur_row);
      if (do_write) begin
         rsp_in.status       = ST_WRITTEN;
         rsp_in.byte_value   = item.data;
         rsp_in.repeat_count = wr_n;
         rsp_in.plane_index  = cur_plane;
         rsp_in.row_index    = row32[11:0];
         rsp_in.column_start = col32[10:0];
         if (col_sum >= rb_ext) begin
            col_in = '0;
            if (plane_inc >= planes) begin
               plane_in = '0;
               if (row_inc >= hcl) begin
                  row_in            = '0;
                  fin_in            = 1'b1;
                  rsp_in.image_done = 1'b1;
               end else begin
                  row_in = row_inc[ROW_W-1:0];
               end
            end else begin
               plane_in = plane_inc[2:0];
            end
         end else begin
            col_in = col_sum[COL_W-1:0];
         end
         // chunk ended before the image did: drop the write report
         if (item.last && !fin_in) begin
            rsp_in        = '0;
            rsp_in.status = ST_TRUNC;
            err_in        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CONTROL;
         lit_left_ff  <= '0;
         rep_ff       <= '0;
         col_ff       <= '0;
         plane_ff     <= '0;
         row_ff       <= '0;
         fin_ff       <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff     <= phase_in;
            lit_left_ff  <= lit_left_in;
            rep_ff       <= rep_in;
            col_ff       <= col_in;
            plane_ff     <= plane_in;
            row_ff       <= row_in;
            fin_ff       <= fin_in;
            err_ff       <= err_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   a_done_is_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.image_done |-> rsp_ff.status == ST_WRITTEN)
      else $error("image_done on a result that is not a write");

   a_write_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_WRITTEN |-> rsp_ff.repeat_count != 8'd0)
      else $error("write reported with zero copies");

   a_literal_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LITERAL |-> lit_left_ff != 8'd0)
      else $error("literal phase with no bytes left");

   a_repeat_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_REPEAT |-> rep_ff > 8'd1)
      else $error("repeat phase with a run shorter than two");

endmodule

// ----- rtl/core/packbits_bitplane_decoder_unit.sv -----
// PackBits / ByteRun1 bit-plane decoder.
// req_*: one compressed byte per request; tuser flags the first byte of an
//   image (restarts position and clears errors), tlast the final byte of the
//   chunk. rsp_*: one result per request, giving the run written (value,
//   copies, plane, row, starting column) or a status: consumed, truncated,
//   row overrun, bad mode, ignored. tlast on rsp marks the write that
//   completes the image.
// csr_*: write-only registers (mode, width, height, planes); write them only
//   while no request is in flight.
// Throughput: one request per cycle while rsp_tready keeps the result
//   register draining. The back-end position tracker updates its whole
//   state as each byte is popped, so bytes stream back to back.
// Path: an accepted request is written into the queue; the queue head is
//   decoded combinationally and the result register loads it onto rsp.
// When rsp_tready is low the result register holds, the queue (two entries by
//   default) fills, and req_tready drops once it is full.
// Reset (synchronous, active high) empties the queue, drops rsp_tvalid,
//   loads the register defaults and returns the decoder to the control-byte
//   phase at plane 0, row 0, column 0.
module packbits_bitplane_decoder_unit
   import pbd_pkg::*;
#(
   parameter int MAX_PLANES  = MAX_PLANES_DEF,
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic [0:0]  req_tuser,   // first_byte
   input  logic        req_tlast,   // last_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_value[7:0], repeat_count[15:8], plane_index[18:16],
   // row_index[30:19], column_start[41:31], zero fill [47:42]
   output logic [47:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast,   // image_done

   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [14:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     push;
   item_type push_item;
   item_type head;
   logic     queue_full;
   logic     queue_has;
   logic     pop;
   rsp_type  rsp;

   // register file: truncate the write data to each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_RST;
         cfg_ff.width  <= WIDTH_RST;
         cfg_ff.height <= HEIGHT_RST;
         cfg_ff.planes <= PLANES_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MODE:   cfg_ff.mode   <= csr_wdata[7:0];
            CSR_WIDTH:  cfg_ff.width  <= csr_wdata;
            CSR_HEIGHT: cfg_ff.height <= csr_wdata[12:0];
            CSR_PLANES: cfg_ff.planes <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // front end: accept and classify control bytes
   pbd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .data_byte  (req_tdata),
      .first_byte (req_tuser[0]),
      .last_byte  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   // decouple the front end from the position tracker
   pbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .full      (queue_full),
      .not_empty (queue_has)
   );

   // back end: decode state, position, result register
   pbd_back #(
      .MAX_PLANES (MAX_PLANES),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (queue_has),
      .item      (head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the result fields, lowest field first
   assign rsp_tdata = {6'd0, rsp.column_start, rsp.row_index, rsp.plane_index,
                       rsp.repeat_count, rsp.byte_value};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.image_done;

endmodule
